// ===== rtl/cts_pkg.sv =====
// Package: shared types and codes for the coprocessor task scheduler.
`default_nettype none

package cts_pkg;

  // Default width of a task identifier
  localparam int TASK_ID_BITS_DEFAULT = 8;

  localparam int ACTION_BITS   = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int FRAME_BITS    = 32;
  localparam int RESET_CNT_BITS = 7;
  localparam logic [RESET_CNT_BITS-1:0] RESET_CNT_MAX = '1;

  // Event codes carried by a request
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_TICK       = 3'd0,
    ACT_RSP_DONE   = 3'd1,
    ACT_RDP_DONE   = 3'd2,
    ACT_QUEUE_AUD  = 3'd3,
    ACT_QUEUE_GFX  = 3'd4,
    ACT_SUBMIT_GFX = 3'd5,
    ACT_PRERESET   = 3'd6,
    ACT_NOP        = 3'd7
  } action_t;

  // Which class holds the coprocessor; also the code of a started task
  typedef enum logic [1:0] {
    RC_NONE  = 2'd0,
    RC_AUDIO = 2'd1,
    RC_GFX   = 2'd2
  } run_class_t;

  // Status of the current graphics task
  typedef enum logic [2:0] {
    GS_WAIT    = 3'd0,
    GS_RUN     = 3'd1,
    GS_YIELD   = 3'd2,
    GS_RSPDONE = 3'd3,
    GS_RDPDONE = 3'd4
  } gfx_status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_AUDIO_ENABLE    = 2'd0,
    CFG_AUDIO_CLIENT_ON = 2'd1,
    CFG_GFX_CLIENT_ON   = 2'd2
  } cfg_idx_t;

  // Configuration bits handed to the scheduling core
  typedef struct packed {
    logic audio_enable;
    logic audio_client_on;
    logic gfx_client_on;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/cts_req_if.sv =====
// Interface: event request channel into the scheduler.
`default_nettype none

interface cts_req_if #(
  parameter int ID_BITS = cts_pkg::TASK_ID_BITS_DEFAULT
);
  logic                           valid;
  logic                           ready;
  logic [cts_pkg::ACTION_BITS-1:0] action;
  logic [ID_BITS-1:0]             task_id;
  logic                           wants_notify;
  logic                           rsp_yielded;

  modport source (output valid, action, task_id, wants_notify, rsp_yielded, input ready);
  modport sink   (input valid, action, task_id, wants_notify, rsp_yielded, output ready);
endinterface

`default_nettype wire

// ===== rtl/cts_res_if.sv =====
// Interface: result channel out of the scheduler.
`default_nettype none

interface cts_res_if #(
  parameter int ID_BITS = cts_pkg::TASK_ID_BITS_DEFAULT
);
  logic                              valid;
  logic                              ready;
  logic [1:0]                        started;
  logic [ID_BITS-1:0]                started_id;
  logic                              yield_request;
  logic                              audio_done_notify;
  logic [ID_BITS-1:0]                audio_done_id;
  logic                              gfx_done_notify;
  logic [ID_BITS-1:0]                gfx_done_id;
  logic                              tick_audio_client;
  logic                              tick_gfx_client;
  logic [cts_pkg::FRAME_BITS-1:0]     frame_count;
  logic [cts_pkg::RESET_CNT_BITS-1:0] reset_count;

  modport source (output valid, started, started_id, yield_request, audio_done_notify,
                  audio_done_id, gfx_done_notify, gfx_done_id, tick_audio_client,
                  tick_gfx_client, frame_count, reset_count, input ready);
  modport sink   (input valid, started, started_id, yield_request, audio_done_notify,
                  audio_done_id, gfx_done_notify, gfx_done_id, tick_audio_client,
                  tick_gfx_client, frame_count, reset_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/cts_cfg_if.sv =====
// Interface: configuration write channel.
`default_nettype none

interface cts_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cts_pkg::CFG_IDX_BITS-1:0] index;
  logic                             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cts_cfg_regs.sv =====
// Module: configuration registers of the scheduler.
`default_nettype none

module cts_cfg_regs (
  input  wire logic      clk,
  input  wire logic      rst,
  cts_cfg_if.sink        cfg,
  output cts_pkg::cfg_t  cfg_bits
);

  cts_pkg::cfg_t regs;

  // Always take writes
  assign cfg.ready = 1'b1;
  assign cfg_bits  = regs;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.audio_enable    <= 1'b1;
      regs.audio_client_on <= 1'b0;
      regs.gfx_client_on   <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        cts_pkg::CFG_AUDIO_ENABLE:    regs.audio_enable    <= cfg.data;
        cts_pkg::CFG_AUDIO_CLIENT_ON: regs.audio_client_on <= cfg.data;
        cts_pkg::CFG_GFX_CLIENT_ON:   regs.gfx_client_on   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cts_core.sv =====
// Module: scheduling state and the per-event next-state and result logic.
`default_nettype none

module cts_core #(
  parameter int ID_BITS = cts_pkg::TASK_ID_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               advance,
  input  wire cts_pkg::cfg_t                      cfg_bits,
  input  wire logic [cts_pkg::ACTION_BITS-1:0]    action,
  input  wire logic [ID_BITS-1:0]                 task_id,
  input  wire logic                               wants_notify,
  input  wire logic                               rsp_yielded,
  output logic [1:0]                              started,
  output logic [ID_BITS-1:0]                      started_id,
  output logic                                    yield_request,
  output logic                                    audio_done_notify,
  output logic [ID_BITS-1:0]                      audio_done_id,
  output logic                                    gfx_done_notify,
  output logic [ID_BITS-1:0]                      gfx_done_id,
  output logic                                    tick_audio_client,
  output logic                                    tick_gfx_client,
  output logic [cts_pkg::FRAME_BITS-1:0]          frame_count,
  output logic [cts_pkg::RESET_CNT_BITS-1:0]      reset_count
);

  // State registers: valid flags reset, notify flags and identifiers do not
  cts_pkg::run_class_t  rc, rc_next;
  cts_pkg::gfx_status_t gs, gs_next;
  logic ac_v, ac_n, gc_v, gc_n, an_v, an_n, gn_v, gn_n, aq_v, aq_n, gq_v, gq_n;
  logic ac_v_next, ac_n_next, gc_v_next, gc_n_next, an_v_next, an_n_next;
  logic gn_v_next, gn_n_next, aq_v_next, aq_n_next, gq_v_next, gq_n_next;
  logic [ID_BITS-1:0] ac_id, gc_id, an_id, gn_id, aq_id, gq_id;
  logic [ID_BITS-1:0] ac_id_next, gc_id_next, an_id_next, gn_id_next;
  logic [ID_BITS-1:0] aq_id_next, gq_id_next;
  logic [cts_pkg::FRAME_BITS-1:0]     ticks, ticks_next;
  logic [cts_pkg::RESET_CNT_BITS-1:0] rtimer, rtimer_next;

  // Work out one event against the current state
  always_comb begin
    logic do_launch;
    logic do_finish;
    do_launch = 1'b0;
    do_finish = 1'b0;

    rc_next = rc;         gs_next = gs;
    ac_v_next = ac_v;     ac_n_next = ac_n;     ac_id_next = ac_id;
    gc_v_next = gc_v;     gc_n_next = gc_n;     gc_id_next = gc_id;
    an_v_next = an_v;     an_n_next = an_n;     an_id_next = an_id;
    gn_v_next = gn_v;     gn_n_next = gn_n;     gn_id_next = gn_id;
    aq_v_next = aq_v;     aq_n_next = aq_n;     aq_id_next = aq_id;
    gq_v_next = gq_v;     gq_n_next = gq_n;     gq_id_next = gq_id;
    ticks_next  = ticks;
    rtimer_next = rtimer;

    started           = cts_pkg::RC_NONE;
    started_id        = '0;
    yield_request     = 1'b0;
    audio_done_notify = 1'b0;
    audio_done_id     = '0;
    gfx_done_notify   = 1'b0;
    gfx_done_id       = '0;
    tick_audio_client = 1'b0;
    tick_gfx_client   = 1'b0;

    unique case (cts_pkg::action_t'(action))
      cts_pkg::ACT_TICK: begin
        ticks_next = ticks + 1'b1;
        if (rtimer != '0 && rtimer != cts_pkg::RESET_CNT_MAX) begin
          rtimer_next = rtimer + 1'b1;
        end
        // Promote queued to next, then next to current
        if (aq_v) begin
          an_v_next = 1'b1; an_n_next = aq_n; an_id_next = aq_id; aq_v_next = 1'b0;
        end
        if (gq_v) begin
          gn_v_next = 1'b1; gn_n_next = gq_n; gn_id_next = gq_id; gq_v_next = 1'b0;
        end
        if (!ac_v_next && an_v_next) begin
          ac_v_next = 1'b1; ac_n_next = an_n_next; ac_id_next = an_id_next;
          an_v_next = 1'b0;
        end
        if (!gc_v_next && gn_v_next) begin
          gc_v_next = 1'b1; gc_n_next = gn_n_next; gc_id_next = gn_id_next;
          gn_v_next = 1'b0;
          gs_next = cts_pkg::GS_WAIT;
        end
        // Audio preempts running graphics by a yield
        if (ac_v_next) begin
          if (rc == cts_pkg::RC_GFX) begin
            gs_next = cts_pkg::GS_YIELD;
            yield_request = 1'b1;
          end else if (rc != cts_pkg::RC_AUDIO) begin
            do_launch = 1'b1;
          end
        end else if (rc != cts_pkg::RC_AUDIO && rc != cts_pkg::RC_GFX) begin
          if (gc_v_next && gs_next != cts_pkg::GS_RSPDONE) begin
            rc_next = cts_pkg::RC_GFX;
            gs_next = cts_pkg::GS_RUN;
            started = cts_pkg::RC_GFX;
            started_id = gc_id_next;
          end
        end
        tick_audio_client = cfg_bits.audio_client_on;
        tick_gfx_client   = cfg_bits.gfx_client_on;
      end
      cts_pkg::ACT_RSP_DONE: begin
        if (rc == cts_pkg::RC_GFX) begin
          rc_next = cts_pkg::RC_NONE;
          if (gs == cts_pkg::GS_YIELD) begin
            if (!rsp_yielded) gs_next = cts_pkg::GS_RSPDONE;
            do_launch = 1'b1;
          end else begin
            gs_next = cts_pkg::GS_RSPDONE;
          end
        end else if (rc == cts_pkg::RC_AUDIO) begin
          do_finish = 1'b1;
        end else begin
          rc_next = cts_pkg::RC_NONE;
        end
      end
      cts_pkg::ACT_RDP_DONE: begin
        if (gc_v && rc != cts_pkg::RC_GFX) begin
          if (gc_n) begin
            gfx_done_notify = 1'b1;
            gfx_done_id = gc_id;
          end
          gs_next = cts_pkg::GS_RDPDONE;
          gc_v_next = 1'b0;
        end
      end
      cts_pkg::ACT_QUEUE_AUD: begin
        if (cfg_bits.audio_enable) begin
          aq_v_next = 1'b1; aq_n_next = wants_notify; aq_id_next = task_id;
        end
      end
      cts_pkg::ACT_QUEUE_GFX: begin
        gq_v_next = 1'b1; gq_n_next = wants_notify; gq_id_next = task_id;
      end
      cts_pkg::ACT_SUBMIT_GFX: begin
        if (!gc_v) begin
          gc_v_next = 1'b1; gc_n_next = wants_notify; gc_id_next = task_id;
          gs_next = cts_pkg::GS_WAIT;
          gn_v_next = 1'b0;
          if (rc != cts_pkg::RC_AUDIO && rc != cts_pkg::RC_GFX) begin
            rc_next = cts_pkg::RC_GFX;
            gs_next = cts_pkg::GS_RUN;
            started = cts_pkg::RC_GFX;
            started_id = task_id;
          end
        end else begin
          gn_v_next = 1'b1; gn_n_next = wants_notify; gn_id_next = task_id;
        end
      end
      cts_pkg::ACT_PRERESET: begin
        rtimer_next = {{(cts_pkg::RESET_CNT_BITS-1){1'b0}}, 1'b1};
      end
      default: ;
    endcase

    // Launch the current audio task, or retire it at once when audio is off
    if (do_launch) begin
      if (!ac_v_next) begin
        rc_next = cts_pkg::RC_NONE;
      end else if (cfg_bits.audio_enable) begin
        rc_next = cts_pkg::RC_AUDIO;
        started = cts_pkg::RC_AUDIO;
        started_id = ac_id_next;
      end else begin
        do_finish = 1'b1;
      end
    end

    // Audio leaves the coprocessor: resume graphics, post the done notice
    if (do_finish) begin
      rc_next = cts_pkg::RC_NONE;
      if (gc_v_next && gs_next != cts_pkg::GS_RSPDONE) begin
        rc_next = cts_pkg::RC_GFX;
        gs_next = cts_pkg::GS_RUN;
        started = cts_pkg::RC_GFX;
        started_id = gc_id_next;
      end
      if (ac_v_next && ac_n_next) begin
        audio_done_notify = 1'b1;
        audio_done_id = ac_id_next;
      end
      ac_v_next = 1'b0;
    end

    frame_count = ticks_next;
    reset_count = rtimer_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rc <= cts_pkg::RC_NONE;
      gs <= cts_pkg::GS_WAIT;
      ac_v <= 1'b0; gc_v <= 1'b0; an_v <= 1'b0;
      gn_v <= 1'b0; aq_v <= 1'b0; gq_v <= 1'b0;
      ticks  <= '0;
      rtimer <= '0;
    end else if (advance) begin
      rc <= rc_next;
      gs <= gs_next;
      ac_v <= ac_v_next; gc_v <= gc_v_next; an_v <= an_v_next;
      gn_v <= gn_v_next; aq_v <= aq_v_next; gq_v <= gq_v_next;
      ticks  <= ticks_next;
      rtimer <= rtimer_next;
    end
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (advance) begin
      ac_n <= ac_n_next; ac_id <= ac_id_next;
      gc_n <= gc_n_next; gc_id <= gc_id_next;
      an_n <= an_n_next; an_id <= an_id_next;
      gn_n <= gn_n_next; gn_id <= gn_id_next;
      aq_n <= aq_n_next; aq_id <= aq_id_next;
      gq_n <= gq_n_next; gq_id <= gq_id_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/coprocessor_task_scheduler.sv =====
// Top level: coprocessor task scheduler with request register and result register.
// A request accepted into the request register moves into the result register once
// that register is free, and the result is offered there until it is taken.
// Throughput: one request per cycle while the results are taken; the state
// update is one pass of logic between the request register and the result register.
// Reset (synchronous, active high) empties both registers and clears all slots.
`default_nettype none

module coprocessor_task_scheduler #(
  parameter int TASK_ID_BITS = cts_pkg::TASK_ID_BITS_DEFAULT
) (
  input wire logic    clk,
  input wire logic    rst,
  cts_req_if.sink     req,
  cts_res_if.source   res,
  cts_cfg_if.sink     cfg
);

  logic                            in_valid;
  logic [cts_pkg::ACTION_BITS-1:0] in_action;
  logic [TASK_ID_BITS-1:0]         in_task_id;
  logic                            in_wants_notify;
  logic                            in_rsp_yielded;
  logic                            advance;
  cts_pkg::cfg_t                   cfg_bits;

  logic [1:0]                         c_started;
  logic [TASK_ID_BITS-1:0]            c_started_id, c_audio_done_id, c_gfx_done_id;
  logic                               c_yield, c_audio_done, c_gfx_done;
  logic                               c_tick_audio, c_tick_gfx;
  logic [cts_pkg::FRAME_BITS-1:0]     c_frame_count;
  logic [cts_pkg::RESET_CNT_BITS-1:0] c_reset_count;

  // Move a request into the result register when that register frees up
  assign advance   = in_valid && (!res.valid || res.ready);
  assign req.ready = !in_valid || advance;

  cts_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_bits (cfg_bits)
  );

  cts_core #(.ID_BITS(TASK_ID_BITS)) u_core (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .cfg_bits          (cfg_bits),
    .action            (in_action),
    .task_id           (in_task_id),
    .wants_notify      (in_wants_notify),
    .rsp_yielded       (in_rsp_yielded),
    .started           (c_started),
    .started_id        (c_started_id),
    .yield_request     (c_yield),
    .audio_done_notify (c_audio_done),
    .audio_done_id     (c_audio_done_id),
    .gfx_done_notify   (c_gfx_done),
    .gfx_done_id       (c_gfx_done_id),
    .tick_audio_client (c_tick_audio),
    .tick_gfx_client   (c_tick_gfx),
    .frame_count       (c_frame_count),
    .reset_count       (c_reset_count)
  );

  // Request register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Request register payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_action       <= req.action;
      in_task_id      <= req.task_id;
      in_wants_notify <= req.wants_notify;
      in_rsp_yielded  <= req.rsp_yielded;
    end
  end

  // Result register valid: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res.started           <= c_started;
      res.started_id        <= c_started_id;
      res.yield_request     <= c_yield;
      res.audio_done_notify <= c_audio_done;
      res.audio_done_id     <= c_audio_done_id;
      res.gfx_done_notify   <= c_gfx_done;
      res.gfx_done_id       <= c_gfx_done_id;
      res.tick_audio_client <= c_tick_audio;
      res.tick_gfx_client   <= c_tick_gfx;
      res.frame_count       <= c_frame_count;
      res.reset_count       <= c_reset_count;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cts_checker.sv =====
// Checker: port-level properties of the scheduler, bound to the top level.
`default_nettype none

module cts_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [1:0] res_started,
  input wire logic       res_yield_request
);

  // A result waiting to be taken stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before it was taken");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered right after reset");

  // Only audio or graphics can start
  a_start_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_started == cts_pkg::RC_NONE || res_started == cts_pkg::RC_AUDIO ||
                   res_started == cts_pkg::RC_GFX))
    else $error("invalid start class");

  // A yield is asked only of running graphics, so nothing starts with it
  a_yield_no_start: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_yield_request |-> res_started == cts_pkg::RC_NONE)
    else $error("task started together with a yield request");

endmodule

bind coprocessor_task_scheduler cts_checker u_cts_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_started       (res.started),
  .res_yield_request (res.yield_request)
);

`default_nettype wire

// ===== bench/coprocessor_task_scheduler_tb.sv =====
// Testbench: self-checking random and directed test of the coprocessor task scheduler.
`timescale 1ns / 1ps

module coprocessor_task_scheduler_tb;

  localparam int ID_W         = 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 100;
  localparam int DRAIN_CYCLES = 4;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic            valid;
    logic            notify;
    logic [ID_W-1:0] id;
  } slot_t;

  typedef struct packed {
    cts_pkg::action_t action;
    logic [ID_W-1:0]  task_id;
    logic             wants_notify;
    logic             rsp_yielded;
  } sched_event_t;

  typedef struct packed {
    cts_pkg::run_class_t                started;
    logic [ID_W-1:0]                    started_id;
    logic                               yield_request;
    logic                               audio_done_notify;
    logic [ID_W-1:0]                    audio_done_id;
    logic                               gfx_done_notify;
    logic [ID_W-1:0]                    gfx_done_id;
    logic                               tick_audio_client;
    logic                               tick_gfx_client;
    logic [cts_pkg::FRAME_BITS-1:0]     frame_count;
    logic [cts_pkg::RESET_CNT_BITS-1:0] reset_count;
  } sched_result_t;

  typedef enum int {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  cts_req_if #(.ID_BITS(ID_W)) req_ch ();
  cts_res_if #(.ID_BITS(ID_W)) res_ch ();
  cts_cfg_if                   cfg_ch ();

  coprocessor_task_scheduler #(.TASK_ID_BITS(ID_W)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  // Scheduler mirror: slots, ownership and configuration
  cts_pkg::run_class_t                owner;
  cts_pkg::gfx_status_t               gstat;
  slot_t                              aud_cur, gfx_cur, aud_nxt, gfx_nxt, aud_q, gfx_q;
  logic [cts_pkg::FRAME_BITS-1:0]     frames;
  logic [cts_pkg::RESET_CNT_BITS-1:0] rst_timer;
  logic                               cfg_audio_en, cfg_aud_client, cfg_gfx_client;
  sched_result_t                      outcome;

  sched_event_t  event_backlog[$];
  sched_result_t owed_results[$];

  int items_queued  = 0;
  int items_taken   = 0;
  int results_taken = 0;
  int cfg_writes    = 0;
  int fault_count   = 0;
  int idle_cycles   = 0;
  int n_audio_starts = 0;
  int n_gfx_starts   = 0;
  int n_yields       = 0;
  int n_notices      = 0;
  int peak_rcount    = 0;

  logic req_fire_q;
  logic hold_off    = 1'b0;
  logic pressure_go = 1'b0;

  function automatic void launch_gfx();
    owner              = cts_pkg::RC_GFX;
    gstat              = cts_pkg::GS_RUN;
    outcome.started    = cts_pkg::RC_GFX;
    outcome.started_id = gfx_cur.id;
  endfunction

  // Audio leaves the coprocessor finished; graphics resumes if it still needs it
  function automatic void retire_audio();
    owner = cts_pkg::RC_NONE;
    if (gfx_cur.valid && gstat != cts_pkg::GS_RSPDONE) launch_gfx();
    if (aud_cur.valid && aud_cur.notify) begin
      outcome.audio_done_notify = 1'b1;
      outcome.audio_done_id     = aud_cur.id;
    end
    aud_cur.valid = 1'b0;
  endfunction

  function automatic void run_audio();
    if (!aud_cur.valid) begin
      owner = cts_pkg::RC_NONE;
    end else if (cfg_audio_en) begin
      owner              = cts_pkg::RC_AUDIO;
      outcome.started    = cts_pkg::RC_AUDIO;
      outcome.started_id = aud_cur.id;
    end else begin
      owner = cts_pkg::RC_AUDIO;
      retire_audio();
    end
  endfunction

  // Apply one event to the mirror and return the result it produces
  function automatic sched_result_t schedule_event(input sched_event_t ev);
    outcome         = '0;
    outcome.started = cts_pkg::RC_NONE;
    case (ev.action)
      cts_pkg::ACT_TICK: begin
        frames++;
        if (rst_timer != '0 && rst_timer != cts_pkg::RESET_CNT_MAX) rst_timer++;
        if (aud_q.valid) begin
          aud_nxt     = aud_q;
          aud_q.valid = 1'b0;
        end
        if (gfx_q.valid) begin
          gfx_nxt     = gfx_q;
          gfx_q.valid = 1'b0;
        end
        if (!aud_cur.valid && aud_nxt.valid) begin
          aud_cur       = aud_nxt;
          aud_nxt.valid = 1'b0;
        end
        if (!gfx_cur.valid && gfx_nxt.valid) begin
          gfx_cur       = gfx_nxt;
          gfx_nxt.valid = 1'b0;
          gstat         = cts_pkg::GS_WAIT;
        end
        // pending audio preempts running graphics
        if (aud_cur.valid) begin
          if (owner == cts_pkg::RC_GFX) begin
            gstat                 = cts_pkg::GS_YIELD;
            outcome.yield_request = 1'b1;
          end else if (owner != cts_pkg::RC_AUDIO) begin
            run_audio();
          end
        end else if (owner == cts_pkg::RC_NONE && gfx_cur.valid &&
                     gstat != cts_pkg::GS_RSPDONE) begin
          launch_gfx();
        end
        outcome.tick_audio_client = cfg_aud_client;
        outcome.tick_gfx_client   = cfg_gfx_client;
      end
      cts_pkg::ACT_RSP_DONE: begin
        if (owner == cts_pkg::RC_GFX) begin
          owner = cts_pkg::RC_NONE;
          if (gstat == cts_pkg::GS_YIELD) begin
            if (!ev.rsp_yielded) gstat = cts_pkg::GS_RSPDONE;
            run_audio();
          end else begin
            gstat = cts_pkg::GS_RSPDONE;
          end
        end else if (owner == cts_pkg::RC_AUDIO) begin
          retire_audio();
        end else begin
          owner = cts_pkg::RC_NONE;
        end
      end
      cts_pkg::ACT_RDP_DONE: begin
        if (gfx_cur.valid && owner != cts_pkg::RC_GFX) begin
          if (gfx_cur.notify) begin
            outcome.gfx_done_notify = 1'b1;
            outcome.gfx_done_id     = gfx_cur.id;
          end
          gstat         = cts_pkg::GS_RDPDONE;
          gfx_cur.valid = 1'b0;
        end
      end
      cts_pkg::ACT_QUEUE_AUD: begin
        if (cfg_audio_en)
          aud_q = slot_t'{valid: 1'b1, notify: ev.wants_notify, id: ev.task_id};
      end
      cts_pkg::ACT_QUEUE_GFX: begin
        gfx_q = slot_t'{valid: 1'b1, notify: ev.wants_notify, id: ev.task_id};
      end
      cts_pkg::ACT_SUBMIT_GFX: begin
        if (!gfx_cur.valid) begin
          gfx_cur       = slot_t'{valid: 1'b1, notify: ev.wants_notify, id: ev.task_id};
          gstat         = cts_pkg::GS_WAIT;
          gfx_nxt.valid = 1'b0;
          if (owner == cts_pkg::RC_NONE) launch_gfx();
        end else begin
          gfx_nxt = slot_t'{valid: 1'b1, notify: ev.wants_notify, id: ev.task_id};
        end
      end
      cts_pkg::ACT_PRERESET: rst_timer = cts_pkg::RESET_CNT_BITS'(1);
      default: ;
    endcase
    outcome.frame_count = frames;
    outcome.reset_count = rst_timer;
    return outcome;
  endfunction

  task automatic show_result(input string tag, input sched_result_t r);
    $display("  %s: start=%0d/%02h yield=%0b adone=%0b/%02h gdone=%0b/%02h clients=%0b%0b",
             tag, r.started, r.started_id, r.yield_request, r.audio_done_notify,
             r.audio_done_id, r.gfx_done_notify, r.gfx_done_id, r.tick_audio_client,
             r.tick_gfx_client);
    $display("  %s: frame=%0d reset_count=%0d", tag, r.frame_count, r.reset_count);
  endtask

  // Monitor: track config writes, check results, predict accepted requests
  sched_event_t  seen_ev;
  sched_result_t got, want;
  logic          bad;

  always @(posedge clk) begin
    if (rst) begin
      owner          = cts_pkg::RC_NONE;
      gstat          = cts_pkg::GS_WAIT;
      aud_cur        = '0;
      gfx_cur        = '0;
      aud_nxt        = '0;
      gfx_nxt        = '0;
      aud_q          = '0;
      gfx_q          = '0;
      frames         = '0;
      rst_timer      = '0;
      cfg_audio_en   = 1'b1;
      cfg_aud_client = 1'b0;
      cfg_gfx_client = 1'b0;
      owed_results.delete();
      req_fire_q <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cts_pkg::cfg_idx_t'(cfg_ch.index))
          cts_pkg::CFG_AUDIO_ENABLE:    cfg_audio_en   = cfg_ch.data;
          cts_pkg::CFG_AUDIO_CLIENT_ON: cfg_aud_client = cfg_ch.data;
          cts_pkg::CFG_GFX_CLIENT_ON:   cfg_gfx_client = cfg_ch.data;
          default: ;
        endcase
        cfg_writes++;
      end

      if (res_ch.valid && res_ch.ready) begin
        got.started           = cts_pkg::run_class_t'(res_ch.started);
        got.started_id        = res_ch.started_id;
        got.yield_request     = res_ch.yield_request;
        got.audio_done_notify = res_ch.audio_done_notify;
        got.audio_done_id     = res_ch.audio_done_id;
        got.gfx_done_notify   = res_ch.gfx_done_notify;
        got.gfx_done_id       = res_ch.gfx_done_id;
        got.tick_audio_client = res_ch.tick_audio_client;
        got.tick_gfx_client   = res_ch.tick_gfx_client;
        got.frame_count       = res_ch.frame_count;
        got.reset_count       = res_ch.reset_count;
        results_taken++;
        if (owed_results.size() == 0) begin
          fault_count++;
          if (fault_count <= SHOW_LIMIT) begin
            $display("[%0t] result with no request outstanding", $realtime);
            show_result("actual", got);
          end
        end else begin
          want = owed_results.pop_front();
          bad = (got.started !== want.started) || (got.started_id !== want.started_id) ||
                (got.yield_request !== want.yield_request) ||
                (got.audio_done_notify !== want.audio_done_notify) ||
                (got.audio_done_id !== want.audio_done_id) ||
                (got.gfx_done_notify !== want.gfx_done_notify) ||
                (got.gfx_done_id !== want.gfx_done_id) ||
                (got.tick_audio_client !== want.tick_audio_client) ||
                (got.tick_gfx_client !== want.tick_gfx_client) ||
                (got.frame_count !== want.frame_count) ||
                (got.reset_count !== want.reset_count);
          if (bad) begin
            fault_count++;
            if (fault_count <= SHOW_LIMIT) begin
              $display("[%0t] mismatch on result %0d", $realtime, results_taken);
              show_result("expected", want);
              show_result("actual  ", got);
            end
          end
          if (want.started == cts_pkg::RC_AUDIO) n_audio_starts++;
          if (want.started == cts_pkg::RC_GFX) n_gfx_starts++;
          if (want.yield_request) n_yields++;
          if (want.audio_done_notify || want.gfx_done_notify) n_notices++;
          if (int'(want.reset_count) > peak_rcount) peak_rcount = int'(want.reset_count);
        end
      end

      if (req_ch.valid && req_ch.ready) begin
        seen_ev.action       = cts_pkg::action_t'(req_ch.action);
        seen_ev.task_id      = req_ch.task_id;
        seen_ev.wants_notify = req_ch.wants_notify;
        seen_ev.rsp_yielded  = req_ch.rsp_yielded;
        owed_results.push_back(schedule_event(seen_ev));
        items_taken++;
      end
      req_fire_q <= req_ch.valid && req_ch.ready;

      // Watchdog: end the run when no handshake happens for too long
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("coprocessor_task_scheduler_tb failed");
        $finish;
      end
    end
  end

  // Request driver: bursts of random length separated by random gaps
  sched_event_t next_ev;
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = 4;
      gap_left   = 0;
    end else if (!req_ch.valid || req_fire_q) begin
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (event_backlog.size() != 0) begin
        next_ev = event_backlog.pop_front();
        req_ch.valid        <= 1'b1;
        req_ch.action       <= next_ev.action;
        req_ch.task_id      <= next_ev.task_id;
        req_ch.wants_notify <= next_ev.wants_notify;
        req_ch.rsp_yielded  <= next_ev.rsp_yielded;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 40);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left   = $urandom_range(1, 6);
          end
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern in a random mode that is redrawn when each run ends
  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 80);
      end else begin
        rx_left--;
      end
      if (hold_off)
        res_ch.ready <= 1'b0;
      else
        case (rx_mode)
          RX_OPEN: res_ch.ready <= 1'b1;
          RX_HALF: res_ch.ready <= 1'($urandom_range(0, 1));
          default: res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end
  end

  // Long receiver hold-off so the block fills up and backs up its input
  initial begin
    while (!pressure_go) @(posedge clk);
    repeat (20) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic add_item(input cts_pkg::action_t act, input logic [ID_W-1:0] id,
                          input logic wn, input logic ry);
    event_backlog.push_back(sched_event_t'{action: act, task_id: id, wants_notify: wn,
                                           rsp_yielded: ry});
    items_queued++;
  endtask

  task automatic add_noise();
    add_item(cts_pkg::action_t'(3'($urandom_range(0, 7))), ID_W'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // One plausible frame: submissions, tick, coprocessor completions, raster done
  task automatic add_frame();
    if ($urandom_range(0, 3) != 0)
      add_item(cts_pkg::ACT_QUEUE_AUD, ID_W'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    case ($urandom_range(0, 2))
      0: add_item(cts_pkg::ACT_SUBMIT_GFX, ID_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      1: add_item(cts_pkg::ACT_QUEUE_GFX, ID_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      default: ;
    endcase
    add_item(cts_pkg::ACT_TICK, ID_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 3))
      add_item(cts_pkg::ACT_RSP_DONE, ID_W'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0));
    if ($urandom_range(0, 1))
      add_item(cts_pkg::ACT_RDP_DONE, ID_W'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Mostly well-formed frames, some noise
  task automatic add_traffic(input int n);
    int goal;
    goal = items_queued + n;
    while (items_queued < goal) begin
      if ($urandom_range(0, 9) < 7) add_frame();
      else add_noise();
    end
  endtask

  task automatic write_cfg(input cts_pkg::cfg_idx_t idx, input logic val);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    while (cfg_writes == seen) @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Wait until every request is taken and every result is back, then drain
  task automatic settle();
    do @(negedge clk); while (items_taken != items_queued || owed_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.action       = '0;
    req_ch.task_id      = '0;
    req_ch.wants_notify = 1'b0;
    req_ch.rsp_yielded  = 1'b0;
    res_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_cfg(cts_pkg::CFG_AUDIO_ENABLE, 1'b1);
    write_cfg(cts_pkg::CFG_AUDIO_CLIENT_ON, 1'b1);
    write_cfg(cts_pkg::CFG_GFX_CLIENT_ON, 1'b0);

    // nothing to act on: bare tick, stray completions, unused action
    add_item(cts_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
    add_item(cts_pkg::ACT_RSP_DONE, 8'hFF, 1'b1, 1'b1);
    add_item(cts_pkg::ACT_RDP_DONE, 8'hFF, 1'b1, 1'b1);
    add_item(cts_pkg::ACT_NOP, 8'hFF, 1'b1, 1'b1);
    // first graphics task starts at once, the second waits as next
    add_item(cts_pkg::ACT_SUBMIT_GFX, 8'hFF, 1'b1, 1'b0);
    add_item(cts_pkg::ACT_SUBMIT_GFX, 8'h00, 1'b0, 1'b1);
    // raster done while graphics still holds the coprocessor
    add_item(cts_pkg::ACT_RDP_DONE, 8'h00, 1'b0, 1'b0);
    // two audio tasks in one frame: the later one wins
    add_item(cts_pkg::ACT_QUEUE_AUD, 8'hA5, 1'b1, 1'b0);
    add_item(cts_pkg::ACT_QUEUE_AUD, 8'h5A, 1'b1, 1'b0);
    // tick: audio preempts graphics, real yield, audio runs and graphics resumes
    add_item(cts_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
    add_item(cts_pkg::ACT_RSP_DONE, 8'h00, 1'b0, 1'b1);
    add_item(cts_pkg::ACT_RSP_DONE, 8'h00, 1'b0, 1'b0);
    // graphics finishes on the coprocessor, then on the rasterizer with notice
    add_item(cts_pkg::ACT_RSP_DONE, 8'h00, 1'b0, 1'b0);
    add_item(cts_pkg::ACT_RDP_DONE, 8'h00, 1'b0, 1'b0);
    // next graphics task comes up on the tick
    add_item(cts_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
    // yield request answered by a plain finish: graphics is not resumed
    add_item(cts_pkg::ACT_QUEUE_AUD, 8'h81, 1'b0, 1'b0);
    add_item(cts_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
    add_item(cts_pkg::ACT_RSP_DONE, 8'h00, 1'b0, 1'b0);
    add_item(cts_pkg::ACT_RSP_DONE, 8'h00, 1'b0, 1'b0);
    add_item(cts_pkg::ACT_RDP_DONE, 8'h00, 1'b0, 1'b0);
    // pre-reset warning starts the reset counter
    add_item(cts_pkg::ACT_PRERESET, 8'h00, 1'b0, 1'b0);
    add_item(cts_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
    // graphics through the queue path; leave audio waiting for the disabled phase
    add_item(cts_pkg::ACT_QUEUE_GFX, 8'h3C, 1'b1, 1'b0);
    add_item(cts_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
    add_item(cts_pkg::ACT_QUEUE_AUD, 8'h7E, 1'b1, 1'b0);
    settle();

    // audio disabled: leftover audio retires at once
    write_cfg(cts_pkg::CFG_AUDIO_ENABLE, 1'b0);
    write_cfg(cts_pkg::CFG_AUDIO_CLIENT_ON, 1'b0);
    write_cfg(cts_pkg::CFG_GFX_CLIENT_ON, 1'b1);
    add_traffic(70);
    settle();

    // everything on, with a long receiver hold-off
    write_cfg(cts_pkg::CFG_AUDIO_ENABLE, 1'b1);
    write_cfg(cts_pkg::CFG_AUDIO_CLIENT_ON, 1'b1);
    add_traffic(100);
    add_item(cts_pkg::ACT_QUEUE_AUD, 8'hC3, 1'b1, 1'b0);
    pressure_go = 1'b1;
    settle();

    write_cfg(cts_pkg::CFG_AUDIO_ENABLE, 1'b0);
    write_cfg(cts_pkg::CFG_GFX_CLIENT_ON, 1'b0);
    add_traffic(50);
    settle();

    // reset counter runs up to saturation
    write_cfg(cts_pkg::CFG_AUDIO_ENABLE, 1'b1);
    write_cfg(cts_pkg::CFG_AUDIO_CLIENT_ON, 1'b0);
    add_item(cts_pkg::ACT_PRERESET, 8'h00, 1'b0, 1'b0);
    repeat (130) add_item(cts_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0);
    add_traffic(30);
    settle();

    fault_count += owed_results.size();
    $display("run covered %0d requests and %0d results over five configurations",
             items_taken, results_taken);
    $display("audio starts %0d, graphics starts %0d, yields %0d, done notices %0d",
             n_audio_starts, n_gfx_starts, n_yields, n_notices);
    $display("highest reset count %0d", peak_rcount);
    if (fault_count == 0)
      $display("coprocessor_task_scheduler_tb passed");
    else
      $display("coprocessor_task_scheduler_tb failed");
    $finish;
  end

endmodule
